FILE: hdl/bank_switch_irq_mapper_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the mapper RTL.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef BANK_SWITCH_IRQ_MAPPER_TOP_MACROS_SVH
`define BANK_SWITCH_IRQ_MAPPER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BSIM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BSIM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/bsim_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsim_pkg
// Types and constants of the bank switching mapper with IRQ counter.
// ----------------------------------------------------------------------------
package bsim_pkg;

    // Field widths.
    localparam int CMD_W      = 2;
    localparam int ADDR_W     = 16;
    localparam int DATA_W     = 8;
    localparam int MADDR_W    = 19;
    localparam int PRG_BANK_W = 6;
    localparam int CHR_BANKS  = 8;
    localparam int PRG_SLOTS  = 3;
    localparam int COUNT_W    = 15;

    // Work RAM geometry.
    localparam int WRAM_BYTES = 8192;
    localparam int WRAM_AW    = $clog2(WRAM_BYTES);

    // Default number of program banks.
    localparam int PRG_BANKS_DEF = 64;

    // Command codes.
    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE  = 2'd0,
        CMD_READ   = 2'd1,
        CMD_LOOKUP = 2'd2,
        CMD_TICK   = 2'd3
    } t_cmd;

    // Address decode windows (address masked with WIN_MASK).
    localparam logic [ADDR_W-1:0] WIN_MASK   = 16'hF800;
    localparam logic [ADDR_W-1:0] WIN_SOUND  = 16'h4800;
    localparam logic [ADDR_W-1:0] WIN_CNT_LO = 16'h5000;
    localparam logic [ADDR_W-1:0] WIN_CNT_HI = 16'h5800;
    localparam logic [ADDR_W-1:0] WIN_NT0    = 16'hC000;
    localparam logic [ADDR_W-1:0] WIN_NT1    = 16'hC800;
    localparam logic [ADDR_W-1:0] WIN_NT2    = 16'hD000;
    localparam logic [ADDR_W-1:0] WIN_NT3    = 16'hD800;
    localparam logic [ADDR_W-1:0] WIN_PRG0   = 16'hE000;
    localparam logic [ADDR_W-1:0] WIN_PRG1   = 16'hE800;
    localparam logic [ADDR_W-1:0] WIN_PRG2   = 16'hF000;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 15'h7FFF;

    // Work RAM request from the control logic.
    typedef struct packed {
        logic               we;
        logic               re;
        logic [WRAM_AW-1:0] addr;
        logic [DATA_W-1:0]  wdata;
    } t_ram_req;

    // Result of one item, ahead of the work RAM data.
    typedef struct packed {
        logic [DATA_W-1:0]  read_data;
        logic               read_valid;
        logic               use_ram;
        logic [MADDR_W-1:0] mapped_addr;
        logic               mapped_valid;
        logic [DATA_W-1:0]  nametable_select;
        logic               irq_line;
    } t_result;

endpackage

FILE: hdl/bsim_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsim_in_if
// Input channel: one bus access or tick per transfer.
// ----------------------------------------------------------------------------
interface bsim_in_if;
    logic                          valid;
    logic                          ready;
    logic [bsim_pkg::CMD_W-1:0]    cmd;
    logic [bsim_pkg::ADDR_W-1:0]   address;
    logic [bsim_pkg::DATA_W-1:0]   write_data;

    modport source (output valid, output cmd, output address, output write_data,
                    input ready);
    modport sink   (input valid, input cmd, input address, input write_data,
                    output ready);
endinterface

FILE: hdl/bsim_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsim_out_if
// Output channel: one result per transfer.
// ----------------------------------------------------------------------------
interface bsim_out_if;
    logic                          valid;
    logic                          ready;
    logic [bsim_pkg::DATA_W-1:0]   read_data;
    logic                          read_valid;
    logic [bsim_pkg::MADDR_W-1:0]  mapped_addr;
    logic                          mapped_valid;
    logic [bsim_pkg::DATA_W-1:0]   nametable_select;
    logic                          irq_line;

    modport source (output valid, output read_data, output read_valid,
                    output mapped_addr, output mapped_valid,
                    output nametable_select, output irq_line, input ready);
    modport sink   (input valid, input read_data, input read_valid,
                    input mapped_addr, input mapped_valid,
                    input nametable_select, input irq_line, output ready);
endinterface

FILE: hdl/bsim_wram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsim_wram
// Work RAM with one write port, one registered read port and a clearing
// pass after reset.
// ----------------------------------------------------------------------------
module bsim_wram (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bsim_pkg::t_ram_req            i_req,
    output logic [bsim_pkg::DATA_W-1:0]   o_rdata,
    output logic                          o_busy
);
    import bsim_pkg::*;

    logic [DATA_W-1:0]  r_mem [WRAM_BYTES];
    logic [DATA_W-1:0]  r_rdata;
    logic               r_clr_busy;
    logic [WRAM_AW-1:0] r_clr_addr;
    logic               n_clr_busy;
    logic [WRAM_AW-1:0] n_clr_addr;

    // The clearing pass walks every entry once, then stops.
    always_comb begin
        n_clr_busy = r_clr_busy;
        n_clr_addr = r_clr_addr;
        if (r_clr_busy) begin
            n_clr_addr = r_clr_addr + 1'b1;
            if (&r_clr_addr) begin
                n_clr_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else begin
            r_clr_busy <= n_clr_busy;
            r_clr_addr <= n_clr_addr;
        end
    end

    // Write port: zeros during the clearing pass, requests afterwards.
    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.addr];
        end
    end

    assign o_rdata = r_rdata;
    assign o_busy  = r_clr_busy;

endmodule

FILE: hdl/bsim_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsim_ctrl
// Address decode, bank and nametable registers, IRQ counter, and the
// result of each item ahead of the work RAM data.
// ----------------------------------------------------------------------------
module bsim_ctrl #(
    parameter int PRG_BANKS = bsim_pkg::PRG_BANKS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  bsim_pkg::t_cmd                i_cmd,
    input  logic [bsim_pkg::ADDR_W-1:0]   i_address,
    input  logic [bsim_pkg::DATA_W-1:0]   i_write_data,
    output bsim_pkg::t_ram_req            o_ram_req,
    output bsim_pkg::t_result             o_result
);
    import bsim_pkg::*;

    localparam logic [PRG_BANK_W-1:0] LAST_BANK = PRG_BANK_W'(PRG_BANKS - 1);

    logic [DATA_W-1:0]     r_chr_bank [CHR_BANKS];
    logic [PRG_BANK_W-1:0] r_prg_bank [PRG_SLOTS];
    logic [DATA_W-1:0]     r_nt_bits;
    logic [COUNT_W-1:0]    r_irq_count;
    logic                  r_irq_enable;
    logic                  r_irq_pending;

    logic [DATA_W-1:0]     n_nt_bits;
    logic [COUNT_W-1:0]    n_irq_count;
    logic                  n_irq_enable;
    logic                  n_irq_pending;

    logic [ADDR_W-1:0]     w_win;
    logic                  w_in_wram;
    logic                  w_is_write;
    logic                  w_is_read;
    logic                  w_chr_we;
    logic [2:0]            w_prg_we;
    logic [PRG_BANK_W-1:0] w_mod;
    logic [1:0]            w_slot;
    logic [PRG_BANK_W-1:0] w_bank;

    assign w_win      = i_address & WIN_MASK;
    assign w_in_wram  = (i_address[15:13] == 3'b011);
    assign w_is_write = (i_cmd == CMD_WRITE);
    assign w_is_read  = (i_cmd == CMD_READ);

    // Bank number modulo PRG_BANKS, taken from a constant table over all
    // possible bank values.
    always_comb begin
        w_mod = '0;
        for (int v = 0; v < (1 << PRG_BANK_W); v++) begin
            if (i_write_data[PRG_BANK_W-1:0] == PRG_BANK_W'(v)) begin
                w_mod = PRG_BANK_W'(v % PRG_BANKS);
            end
        end
    end

    // Program bank of a CPU read; the top 8K always maps the last bank.
    assign w_slot = i_address[14:13];
    always_comb begin
        if (w_slot == 2'd3) begin
            w_bank = LAST_BANK;
        end else begin
            w_bank = r_prg_bank[w_slot];
        end
    end

    // Write decode for the bank registers.
    assign w_chr_we    = i_accept && w_is_write && (i_address[15:14] == 2'b10);
    assign w_prg_we[0] = i_accept && w_is_write && (w_win == WIN_PRG0);
    assign w_prg_we[1] = i_accept && w_is_write && (w_win == WIN_PRG1);
    assign w_prg_we[2] = i_accept && w_is_write && (w_win == WIN_PRG2);

    // Next value of nametable bits and the IRQ counter for this item.
    always_comb begin
        n_nt_bits     = r_nt_bits;
        n_irq_count   = r_irq_count;
        n_irq_enable  = r_irq_enable;
        n_irq_pending = r_irq_pending;
        unique case (i_cmd)
            CMD_WRITE: begin
                if (w_win == WIN_CNT_LO) begin
                    n_irq_count[7:0] = i_write_data;
                    n_irq_pending    = 1'b0;
                end else if (w_win == WIN_CNT_HI) begin
                    n_irq_count[14:8] = i_write_data[6:0];
                    n_irq_enable      = i_write_data[7];
                    n_irq_pending     = 1'b0;
                end else if (w_win == WIN_NT0) begin
                    n_nt_bits[1:0] = {1'b0, i_write_data[0]};
                end else if (w_win == WIN_NT1) begin
                    n_nt_bits[3:2] = {1'b0, i_write_data[0]};
                end else if (w_win == WIN_NT2) begin
                    n_nt_bits[5:4] = {1'b0, i_write_data[0]};
                end else if (w_win == WIN_NT3) begin
                    n_nt_bits[7:6] = {1'b0, i_write_data[0]};
                end
            end
            CMD_READ: begin
                if (w_win == WIN_CNT_LO || w_win == WIN_CNT_HI) begin
                    n_irq_pending = 1'b0;
                end
            end
            CMD_LOOKUP: begin
            end
            CMD_TICK: begin
                if (r_irq_enable) begin
                    if (r_irq_count == COUNT_MAX) begin
                        n_irq_pending = 1'b1;
                    end else begin
                        n_irq_count = r_irq_count + 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nt_bits     <= '0;
            r_irq_count   <= '0;
            r_irq_enable  <= 1'b0;
            r_irq_pending <= 1'b0;
            for (int i = 0; i < CHR_BANKS; i++) begin
                r_chr_bank[i] <= '0;
            end
            for (int i = 0; i < PRG_SLOTS; i++) begin
                r_prg_bank[i] <= '0;
            end
        end else if (i_accept) begin
            r_nt_bits     <= n_nt_bits;
            r_irq_count   <= n_irq_count;
            r_irq_enable  <= n_irq_enable;
            r_irq_pending <= n_irq_pending;
            if (w_chr_we) begin
                r_chr_bank[i_address[13:11]] <= i_write_data;
            end
            for (int i = 0; i < PRG_SLOTS; i++) begin
                if (w_prg_we[i]) begin
                    r_prg_bank[i] <= w_mod;
                end
            end
        end
    end

    // Work RAM access for writes and reads of its window.
    always_comb begin
        o_ram_req.we    = i_accept && w_is_write && w_in_wram;
        o_ram_req.re    = i_accept && w_is_read && w_in_wram;
        o_ram_req.addr  = i_address[WRAM_AW-1:0];
        o_ram_req.wdata = i_write_data;
    end

    // Result fields of this item.
    always_comb begin
        o_result                  = '0;
        o_result.nametable_select = n_nt_bits;
        o_result.irq_line         = n_irq_pending;
        if (w_is_read) begin
            if (w_win == WIN_SOUND) begin
                o_result.read_valid = 1'b1;
            end else if (w_win == WIN_CNT_LO) begin
                o_result.read_data  = r_irq_count[7:0];
                o_result.read_valid = 1'b1;
            end else if (w_win == WIN_CNT_HI) begin
                o_result.read_data  = {r_irq_enable, r_irq_count[14:8]};
                o_result.read_valid = 1'b1;
            end else if (w_in_wram) begin
                o_result.read_valid = 1'b1;
                o_result.use_ram    = 1'b1;
            end else if (i_address[15]) begin
                o_result.mapped_addr  = {w_bank, i_address[12:0]};
                o_result.mapped_valid = 1'b1;
            end
        end else if (i_cmd == CMD_LOOKUP) begin
            if (i_address[15:13] == 3'b000) begin
                o_result.mapped_addr  = MADDR_W'({r_chr_bank[i_address[12:10]],
                                                  i_address[9:0]});
                o_result.mapped_valid = 1'b1;
            end
        end
    end

endmodule

FILE: hdl/bank_switch_irq_mapper_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bank_switch_irq_mapper_top
// Cartridge mapper: bank registers, nametable bits, IRQ counter, work RAM.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload
//  i_in_ch   in         cmd, address, write_data
//  o_out_ch  out        read_data, read_valid, mapped_addr, mapped_valid,
//                       nametable_select, irq_line
//
// One item is taken per cycle unless the clear pass or a stalled result holds
// the input; its result is on o_out_ch the cycle after. The work RAM read port
// is registered like the result, so its data arrives with it. After reset the
// work RAM is cleared, one entry per cycle; no item is taken during that pass.
// A stalled result holds the output register and blocks new items.
// ----------------------------------------------------------------------------
module bank_switch_irq_mapper_top #(
    parameter int PRG_BANKS = bsim_pkg::PRG_BANKS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bsim_in_if.sink       i_in_ch,
    bsim_out_if.source    o_out_ch
);
    import bsim_pkg::*;
    `include "bank_switch_irq_mapper_top_macros.svh"

    t_ram_req           w_ram_req;
    t_result            w_result;
    logic [DATA_W-1:0]  w_ram_rdata;
    logic               w_clr_busy;
    logic               w_in_accept;

    t_result            r_res;
    logic               r_out_valid;

    // Accept when clear is done and the output register is free or leaving.
    assign i_in_ch.ready = !w_clr_busy && (!r_out_valid || o_out_ch.ready);
    assign w_in_accept   = i_in_ch.valid && i_in_ch.ready;

    bsim_ctrl #(
        .PRG_BANKS(PRG_BANKS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_in_accept),
        .i_cmd        (t_cmd'(i_in_ch.cmd)),
        .i_address    (i_in_ch.address),
        .i_write_data (i_in_ch.write_data),
        .o_ram_req    (w_ram_req),
        .o_result     (w_result)
    );

    bsim_wram u_wram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_ram_req),
        .o_rdata (w_ram_rdata),
        .o_busy  (w_clr_busy)
    );

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_res <= w_result;
        end
    end

    // Work RAM data joins the result after the read latency.
    assign o_out_ch.valid            = r_out_valid;
    assign o_out_ch.read_data        = r_res.use_ram ? w_ram_rdata : r_res.read_data;
    assign o_out_ch.read_valid       = r_res.read_valid;
    assign o_out_ch.mapped_addr      = r_res.mapped_addr;
    assign o_out_ch.mapped_valid     = r_res.mapped_valid;
    assign o_out_ch.nametable_select = r_res.nametable_select;
    assign o_out_ch.irq_line         = r_res.irq_line;

    `BSIM_ASSERT_NOW(a_no_accept_in_clear, w_clr_busy, !w_in_accept, "item taken during clear")
    `BSIM_ASSERT_NOW(a_no_overrun, r_out_valid && !o_out_ch.ready, !w_in_accept, "result overrun")
    `BSIM_ASSERT_NOW(a_one_kind, r_out_valid, !(r_res.read_valid && r_res.mapped_valid), "both valids")
    `BSIM_ASSERT_NEXT(a_write_quiet, w_in_accept && (i_in_ch.cmd == CMD_WRITE), !(r_res.read_valid || r_res.mapped_valid), "write gave data")

endmodule

FILE: tb/sv/bank_switch_irq_mapper_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bank_switch_irq_mapper_top_test
// Self-checking bench for the cartridge mapper. A scoreboard class predicts
// every result from its own copy of the bank registers, nametable bits, IRQ
// counter and work RAM, and compares each output transfer field by field.
// Stimulus is a directed pass over the decode windows and counter corner
// cases, followed by random bus sequences with bursty input, a patterned
// output stall, one long output hold-off and random full drains.
// ----------------------------------------------------------------------------
module bank_switch_irq_mapper_top_test;
    import bsim_pkg::*;

    localparam int CLK_HALF_NS      = 5;
    localparam int RESET_CYCLES     = 6;
    localparam int RANDOM_ITEMS     = 500;
    localparam int HOLD_OFF_CYCLES  = 60;
    localparam int DRAIN_CYCLES     = 16;
    localparam int TIMEOUT_NS       = 2_000_000;
    localparam int MAX_REPORTS      = 40;
    localparam int MAPPER_PRG_BANKS = PRG_BANKS_DEF;

    // Bus map of the CPU and PPU sides.
    localparam logic [ADDR_W-1:0] WRAM_BASE   = 16'h6000;
    localparam logic [ADDR_W-1:0] PRG_BASE    = 16'h8000;
    localparam logic [ADDR_W-1:0] CHR_REG_END = 16'hC000;
    localparam logic [ADDR_W-1:0] PPU_CHR_END = 16'h2000;
    localparam logic [ADDR_W-1:0] WIN_SPAN    = 16'h07FF;

    // One expected or observed result.
    typedef struct packed {
        logic [DATA_W-1:0]  read_data;
        logic               read_valid;
        logic [MADDR_W-1:0] mapped_addr;
        logic               mapped_valid;
        logic [DATA_W-1:0]  nametable_select;
        logic               irq_line;
    } t_mapper_resp;

    // ------------------------------------------------------------------------
    // Scoreboard: mirrors the mapper state and queues predicted results.
    // ------------------------------------------------------------------------
    class mapper_scoreboard;
        logic [DATA_W-1:0]     chr_bank [CHR_BANKS];
        logic [PRG_BANK_W-1:0] prg_bank [PRG_SLOTS];
        logic [DATA_W-1:0]     nt_bits;
        logic [COUNT_W-1:0]    irq_count;
        logic                  irq_enable;
        logic                  irq_pending;
        logic [DATA_W-1:0]     wram [WRAM_BYTES];
        t_mapper_resp          expected_q[$];
        int unsigned           failures;
        int unsigned           checked;
        int unsigned           n_writes;
        int unsigned           n_reads;
        int unsigned           n_lookups;
        int unsigned           n_ticks;
        int unsigned           n_irq_raised;

        function new();
            foreach (chr_bank[i]) chr_bank[i] = '0;
            foreach (prg_bank[i]) prg_bank[i] = '0;
            foreach (wram[i]) wram[i] = '0;
            nt_bits      = '0;
            irq_count    = '0;
            irq_enable   = 1'b0;
            irq_pending  = 1'b0;
            failures     = 0;
            checked      = 0;
            n_writes     = 0;
            n_reads      = 0;
            n_lookups    = 0;
            n_ticks      = 0;
            n_irq_raised = 0;
        endfunction

        // Applies one bus access to the mirrored state and returns the result.
        function t_mapper_resp map_access(t_cmd cmd, logic [ADDR_W-1:0] a,
                                          logic [DATA_W-1:0] d);
            t_mapper_resp      r;
            logic [ADDR_W-1:0] win;
            int unsigned       bank;
            r    = '0;
            win  = a & WIN_MASK;
            bank = 0;
            case (cmd)
                CMD_WRITE: begin
                    n_writes++;
                    if (win == WIN_CNT_LO) begin
                        irq_count[7:0] = d;
                        irq_pending    = 1'b0;
                    end else if (win == WIN_CNT_HI) begin
                        irq_count[COUNT_W-1:8] = d[6:0];
                        irq_enable             = d[7];
                        irq_pending            = 1'b0;
                    end else if (a >= WRAM_BASE && a < PRG_BASE) begin
                        wram[a[WRAM_AW-1:0]] = d;
                    end else if (a >= PRG_BASE && a < CHR_REG_END) begin
                        chr_bank[a[13:11]] = d;
                    end else if (win == WIN_NT0) begin
                        nt_bits[0] = d[0];
                    end else if (win == WIN_NT1) begin
                        nt_bits[2] = d[0];
                    end else if (win == WIN_NT2) begin
                        nt_bits[4] = d[0];
                    end else if (win == WIN_NT3) begin
                        nt_bits[6] = d[0];
                    end else if (win == WIN_PRG0) begin
                        prg_bank[0] = d[PRG_BANK_W-1:0];
                    end else if (win == WIN_PRG1) begin
                        prg_bank[1] = d[PRG_BANK_W-1:0];
                    end else if (win == WIN_PRG2) begin
                        prg_bank[2] = d[PRG_BANK_W-1:0];
                    end
                end
                CMD_READ: begin
                    n_reads++;
                    if (win == WIN_SOUND) begin
                        r.read_valid = 1'b1;
                    end else if (win == WIN_CNT_LO) begin
                        r.read_data  = irq_count[7:0];
                        r.read_valid = 1'b1;
                        irq_pending  = 1'b0;
                    end else if (win == WIN_CNT_HI) begin
                        r.read_data  = {irq_enable, irq_count[COUNT_W-1:8]};
                        r.read_valid = 1'b1;
                        irq_pending  = 1'b0;
                    end else if (a >= WRAM_BASE && a < PRG_BASE) begin
                        r.read_data  = wram[a[WRAM_AW-1:0]];
                        r.read_valid = 1'b1;
                    end else if (a >= PRG_BASE) begin
                        // The top 8K window is pinned to the last program bank.
                        if (a[14:13] == 2'd3) bank = MAPPER_PRG_BANKS - 1;
                        else bank = prg_bank[a[14:13]];
                        r.mapped_addr  = MADDR_W'(((bank % MAPPER_PRG_BANKS) << 13)
                                                  | a[12:0]);
                        r.mapped_valid = 1'b1;
                    end
                end
                CMD_LOOKUP: begin
                    n_lookups++;
                    if (a < PPU_CHR_END) begin
                        r.mapped_addr  = MADDR_W'({chr_bank[a[12:10]], a[9:0]});
                        r.mapped_valid = 1'b1;
                    end
                end
                default: begin
                    n_ticks++;
                    // The counter parks at its limit and keeps the request up.
                    if (irq_enable) begin
                        if (irq_count == COUNT_MAX) begin
                            if (!irq_pending) n_irq_raised++;
                            irq_pending = 1'b1;
                        end else begin
                            irq_count = irq_count + 1'b1;
                        end
                    end
                end
            endcase
            r.nametable_select = nt_bits;
            r.irq_line         = irq_pending;
            return r;
        endfunction

        function void note_access(t_cmd cmd, logic [ADDR_W-1:0] a, logic [DATA_W-1:0] d);
            expected_q.push_back(map_access(cmd, a, d));
        endfunction

        function void report_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("%0t: %s mismatch on result %0d, expected 0x%0h, actual 0x%0h",
                             $time, name, checked, want, got);
            end
        endfunction

        function void check_response(t_mapper_resp got);
            t_mapper_resp want;
            if (expected_q.size() == 0) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("%0t: unexpected result, expected none, actual 0x%0h",
                             $time, got);
                return;
            end
            want = expected_q.pop_front();
            report_field("read_data", 32'(want.read_data), 32'(got.read_data));
            report_field("read_valid", 32'(want.read_valid), 32'(got.read_valid));
            report_field("mapped_addr", 32'(want.mapped_addr), 32'(got.mapped_addr));
            report_field("mapped_valid", 32'(want.mapped_valid), 32'(got.mapped_valid));
            report_field("nametable_select", 32'(want.nametable_select),
                         32'(got.nametable_select));
            report_field("irq_line", 32'(want.irq_line), 32'(got.irq_line));
            checked++;
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    bsim_in_if  in_ch();
    bsim_out_if out_ch();

    mapper_scoreboard chk;
    int unsigned      items_sent   = 0;
    int unsigned      burst_left   = 0;
    bit               no_gaps      = 1'b0;
    bit               hold_off_req = 1'b0;

    bank_switch_irq_mapper_top #(
        .PRG_BANKS (MAPPER_PRG_BANKS)
    ) u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_ch  (in_ch),
        .o_out_ch (out_ch)
    );

    // Clock generation.
    always begin
        #(CLK_HALF_NS) i_clk = 1'b1;
        #(CLK_HALF_NS) i_clk = 1'b0;
    end

    // Run limit, independent of the stimulus.
    initial begin
        #(TIMEOUT_NS);
        $display("Verification failed");
        $finish;
    end

    // Output ready: changing stall patterns, plus a long hold-off on request.
    initial begin : ready_pattern
        int unsigned mode;
        int unsigned mode_left;
        int unsigned phase;
        mode      = 0;
        mode_left = 0;
        phase     = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                repeat (HOLD_OFF_CYCLES) begin
                    out_ch.ready <= 1'b0;
                    @(negedge i_clk);
                end
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 80);
            end
            mode_left--;
            phase++;
            case (mode)
                0: out_ch.ready <= 1'b1;
                1: out_ch.ready <= ($urandom_range(0, 3) != 0);
                2: out_ch.ready <= (phase % 3 != 0);
                default: out_ch.ready <= ($urandom_range(0, 1) != 0);
            endcase
        end
    end

    // Result monitor.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid === 1'b1 && out_ch.ready) begin
            chk.check_response('{read_data: out_ch.read_data,
                                 read_valid: out_ch.read_valid,
                                 mapped_addr: out_ch.mapped_addr,
                                 mapped_valid: out_ch.mapped_valid,
                                 nametable_select: out_ch.nametable_select,
                                 irq_line: out_ch.irq_line});
        end
    end

    // Offers one access in the current burst and waits for its transfer.
    task automatic send_access(input t_cmd cmd, input logic [ADDR_W-1:0] a,
                               input logic [DATA_W-1:0] d);
        int unsigned idle;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            idle       = no_gaps ? 0 : $urandom_range(0, 6);
            repeat (idle) begin
                @(negedge i_clk);
                in_ch.valid <= 1'b0;
            end
        end
        burst_left--;
        @(negedge i_clk);
        in_ch.valid      <= 1'b1;
        in_ch.cmd        <= cmd;
        in_ch.address    <= a;
        in_ch.write_data <= d;
        do @(posedge i_clk); while (!(in_ch.valid && in_ch.ready));
        chk.note_access(cmd, a, d);
        items_sent++;
    endtask

    // Stops offering and waits until every predicted result has arrived.
    task automatic drain_results();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        burst_left = 0;
        while (chk.expected_q.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [ADDR_W-1:0] win_offset();
        return ADDR_W'($urandom_range(0, WIN_SPAN));
    endfunction

    // Address spread over the decode windows, with window edges favored.
    function automatic logic [ADDR_W-1:0] pick_address();
        logic [ADDR_W-1:0] a;
        case ($urandom_range(0, 5))
            0: a = ADDR_W'($urandom);
            1: a = ADDR_W'($urandom_range(WIN_SOUND, WRAM_BASE - 1));
            2: a = ADDR_W'($urandom_range(WRAM_BASE, PRG_BASE - 1));
            3: a = ADDR_W'($urandom_range(PRG_BASE, 16'hFFFF));
            4: a = ADDR_W'($urandom_range(0, PPU_CHR_END - 1));
            default: a = ADDR_W'({$urandom_range(0, 31), 11'h000})
                         | (($urandom_range(0, 1) != 0) ? WIN_SPAN : '0);
        endcase
        return a;
    endfunction

    task automatic random_access();
        send_access(t_cmd'($urandom_range(0, 3)), pick_address(), DATA_W'($urandom));
    endtask

    // Counter load followed by ticks, often running into the limit.
    task automatic irq_run();
        logic [DATA_W-1:0] lo;
        logic [DATA_W-1:0] hi;
        int unsigned       ticks;
        lo = ($urandom_range(0, 1) != 0) ? DATA_W'($urandom_range(8'hF0, 8'hFF))
                                          : DATA_W'($urandom);
        hi[7]   = ($urandom_range(0, 3) != 0);
        hi[6:0] = ($urandom_range(0, 1) != 0) ? 7'h7F : 7'($urandom);
        send_access(CMD_WRITE, WIN_CNT_LO | win_offset(), lo);
        send_access(CMD_WRITE, WIN_CNT_HI | win_offset(), hi);
        ticks = $urandom_range(1, 24);
        repeat (ticks) begin
            if ($urandom_range(0, 9) == 0)
                send_access(CMD_READ, ((($urandom_range(0, 1) != 0) ? WIN_CNT_HI : WIN_CNT_LO)
                            | win_offset()), DATA_W'($urandom));
            else
                send_access(CMD_TICK, ADDR_W'($urandom), DATA_W'($urandom));
        end
    endtask

    // Writes into a small work RAM region and reads it back.
    task automatic wram_run();
        logic [ADDR_W-1:0] base;
        base = WRAM_BASE + ADDR_W'($urandom_range(0, WRAM_BYTES - 8));
        repeat ($urandom_range(2, 6))
            send_access(CMD_WRITE, base + ADDR_W'($urandom_range(0, 7)), DATA_W'($urandom));
        repeat ($urandom_range(2, 6))
            send_access(CMD_READ, base + ADDR_W'($urandom_range(0, 7)), DATA_W'($urandom));
    endtask

    // Bank or nametable update followed by accesses that use it.
    task automatic bank_run();
        case ($urandom_range(0, 2))
            0: begin
                send_access(CMD_WRITE, PRG_BASE + ADDR_W'($urandom_range(0, 16'h3FFF)),
                            DATA_W'($urandom));
                repeat ($urandom_range(2, 5))
                    send_access(CMD_LOOKUP, ADDR_W'($urandom_range(0, PPU_CHR_END - 1)),
                                DATA_W'($urandom));
            end
            1: begin
                send_access(CMD_WRITE, WIN_PRG0 + ADDR_W'($urandom_range(0, 16'h17FF)),
                            DATA_W'($urandom));
                repeat ($urandom_range(2, 5))
                    send_access(CMD_READ, ADDR_W'($urandom_range(PRG_BASE, 16'hFFFF)),
                                DATA_W'($urandom));
            end
            default: begin
                send_access(CMD_WRITE, WIN_NT0 + ADDR_W'($urandom_range(0, 16'h1FFF)),
                            DATA_W'($urandom));
                random_access();
            end
        endcase
    endtask

    // Reset, directed pass, random sequences, end of run.
    initial begin : stimulus
        int unsigned target;
        int unsigned pick;
        bit          pressure_done;
        chk = new();
        i_rst_n          = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.cmd        = CMD_WRITE;
        in_ch.address    = '0;
        in_ch.write_data = '0;
        pressure_done    = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Counter just below its limit, enabled, then ticked past it.
        send_access(CMD_WRITE, WIN_CNT_LO, 8'hFE);
        send_access(CMD_WRITE, WIN_CNT_HI | WIN_SPAN, 8'hFF);
        send_access(CMD_TICK, 16'h0000, 8'h00);
        send_access(CMD_TICK, 16'hFFFF, 8'hFF);
        send_access(CMD_TICK, 16'h0000, 8'h00);
        // Counter reads clear the request; the held count raises it again.
        send_access(CMD_READ, WIN_CNT_LO | WIN_SPAN, 8'h00);
        send_access(CMD_TICK, 16'h0000, 8'h00);
        send_access(CMD_READ, WIN_CNT_HI, 8'h00);
        // Counter writes clear it; a disabled counter ignores ticks.
        send_access(CMD_WRITE, WIN_CNT_LO, 8'h00);
        send_access(CMD_WRITE, WIN_CNT_HI, 8'h00);
        send_access(CMD_TICK, 16'h0000, 8'h00);
        // Sound port and unmapped reads.
        send_access(CMD_READ, WIN_SOUND | WIN_SPAN, 8'h00);
        send_access(CMD_READ, 16'h0000, 8'h00);
        // Work RAM at both ends.
        send_access(CMD_WRITE, WRAM_BASE, 8'hA5);
        send_access(CMD_WRITE, PRG_BASE - 1, 8'h5A);
        send_access(CMD_READ, PRG_BASE - 1, 8'h00);
        // Character banks and the PPU window.
        send_access(CMD_WRITE, PRG_BASE, 8'hFF);
        send_access(CMD_WRITE, CHR_REG_END - 1, 8'h80);
        send_access(CMD_LOOKUP, 16'h0000, 8'h00);
        send_access(CMD_LOOKUP, PPU_CHR_END - 1, 8'h00);
        send_access(CMD_LOOKUP, PPU_CHR_END, 8'h00);
        // Nametable bits, program banks and the ignored top window.
        send_access(CMD_WRITE, WIN_NT0, 8'h01);
        send_access(CMD_WRITE, WIN_NT1, 8'hFF);
        send_access(CMD_WRITE, WIN_NT2, 8'h01);
        send_access(CMD_WRITE, WIN_NT3 | WIN_SPAN, 8'h01);
        send_access(CMD_WRITE, WIN_PRG0, 8'hFF);
        send_access(CMD_WRITE, WIN_PRG2 | WIN_SPAN, 8'h3F);
        send_access(CMD_WRITE, 16'hF800, 8'hFF);
        send_access(CMD_READ, PRG_BASE, 8'h00);
        send_access(CMD_READ, WIN_NT3 | WIN_SPAN, 8'h00);
        send_access(CMD_READ, 16'hFFFF, 8'h00);

        // Random sequences; one long output hold-off partway through.
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target) begin
            if (!pressure_done && items_sent >= target / 2) begin
                pressure_done = 1'b1;
                drain_results();
                hold_off_req = 1'b1;
                no_gaps      = 1'b1;
                repeat (24) random_access();
                no_gaps = 1'b0;
                drain_results();
            end
            pick = $urandom_range(0, 99);
            if (pick < 20) irq_run();
            else if (pick < 35) wram_run();
            else if (pick < 50) bank_run();
            else random_access();
            if ($urandom_range(0, 59) == 0) drain_results();
        end

        // Wait for the tail, then give stray results time to show up.
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (chk.expected_q.size() != 0) begin
            chk.failures++;
            $display("%0t: %0d results never arrived", $time, chk.expected_q.size());
        end
        $display("Run summary: %0d transfers in, %0d results checked, %0d mismatches.",
                 items_sent, chk.checked, chk.failures);
        $display("Mix: %0d writes, %0d reads, %0d PPU lookups, %0d ticks, IRQ raised %0d times.",
                 chk.n_writes, chk.n_reads, chk.n_lookups, chk.n_ticks, chk.n_irq_raised);
        if (chk.failures == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/bsim_pkg.sv
hdl/bsim_in_if.sv
hdl/bsim_out_if.sv
hdl/bsim_wram.sv
hdl/bsim_ctrl.sv
hdl/bank_switch_irq_mapper_top.sv
tb/sv/bank_switch_irq_mapper_top_test.sv
